FILE: src/vcc_pkg.sv
// Package with the shared types and codes of the four channel volume controller.
`timescale 1ns / 1ps

package vcc_pkg;

  localparam int CHANNELS   = 4;
  localparam int GAIN_BITS  = 8;
  localparam int FRAME_BITS = CHANNELS * GAIN_BITS;
  localparam int CFG_BITS   = 8;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [GAIN_BITS-1:0] gain_t;
  typedef logic [CHANNELS-1:0][GAIN_BITS-1:0] gain_vec_t;

  typedef enum logic [2:0] {
    FN_SET         = 3'd0,
    FN_SET_ALL     = 3'd1,
    FN_STEP_UP     = 3'd2,
    FN_STEP_DOWN   = 3'd3,
    FN_MUTE        = 3'd4,
    FN_TOGGLE_MUTE = 3'd5,
    FN_RESTORE     = 3'd6,
    FN_NOP         = 3'd7
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_HARD_MUTE = 2'd0,
    CFG_MAX_GAIN  = 2'd1,
    CFG_ZERO_CROSS = 2'd2
  } cfg_idx_t;

  // What a lane proposes as the new gain of its channel.
  typedef enum logic [1:0] {
    LK_LOAD = 2'd0,
    LK_UP   = 2'd1,
    LK_DOWN = 2'd2,
    LK_ZERO = 2'd3
  } lane_kind_t;

  typedef struct packed {
    logic over;
    logic changed;
    logic zero;
  } lane_flag_t;

  typedef struct packed {
    logic      frame_valid;
    gain_vec_t frame_word;
    logic      mute_pin;
    logic      muted_now;
    gain_vec_t shown;
  } vcc_result_t;

endpackage

FILE: src/vcc_lane.sv
// One channel lane: proposes the channel's new gain and flags it against the limit.
`timescale 1ns / 1ps

module vcc_lane (
  input  vcc_pkg::lane_kind_t kind,
  input  vcc_pkg::gain_t      cur,
  input  vcc_pkg::gain_t      load,
  input  vcc_pkg::gain_t      step,
  input  vcc_pkg::gain_t      gain_cap,
  output vcc_pkg::gain_t      gain_new,
  output vcc_pkg::lane_flag_t flag
);
  import vcc_pkg::*;

  logic [GAIN_BITS:0] sum;
  gain_t              up_val;
  gain_t              down_val;

  always_comb begin
    sum      = {1'b0, cur} + {1'b0, step};
    up_val   = (sum > {1'b0, gain_cap}) ? gain_cap : sum[GAIN_BITS-1:0];
    down_val = (step > cur) ? '0 : cur - step;
    case (kind)
      LK_LOAD: gain_new = load;
      LK_UP:   gain_new = up_val;
      LK_DOWN: gain_new = down_val;
      LK_ZERO: gain_new = '0;
      default: gain_new = '0;
    endcase
    // A step down from above a lowered limit can still land over it.
    flag.over    = gain_new > gain_cap;
    flag.changed = gain_new != cur;
    flag.zero    = gain_new == '0;
  end

endmodule

FILE: src/vcc_ctrl.sv
// Gain and mute state with the per-channel lanes and the stage that merges their flags.
`timescale 1ns / 1ps

module vcc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  vcc_pkg::func_t       func,
  input  vcc_pkg::gain_vec_t   gains,
  input  vcc_pkg::gain_t       step,
  input  logic                 hard_mode,
  input  vcc_pkg::gain_t       gain_cap,
  output vcc_pkg::vcc_result_t res
);
  import vcc_pkg::*;

  gain_vec_t  cur_r, cur_nxt;
  gain_vec_t  prev_r, prev_nxt;
  logic       muted_r, muted_nxt;
  logic       pin_r, pin_nxt;

  lane_kind_t kind;
  gain_vec_t  load;
  gain_vec_t  cand;
  lane_flag_t [CHANNELS-1:0] flags;

  logic any_over, any_changed, all_zero;
  logic set_en, restore_en, set_apply;

  always_comb begin
    case (func)
      FN_STEP_UP:     kind = LK_UP;
      FN_STEP_DOWN:   kind = LK_DOWN;
      FN_MUTE:        kind = LK_ZERO;
      FN_TOGGLE_MUTE: kind = LK_ZERO;
      default:        kind = LK_LOAD;
    endcase
    for (int i = 0; i < CHANNELS; i++) begin
      load[i] = (func == FN_SET_ALL) ? gains[0] : gains[i];
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    vcc_lane u_lane (
      .kind     (kind),
      .cur      (cur_r[g]),
      .load     (load[g]),
      .step     (step),
      .gain_cap (gain_cap),
      .gain_new (cand[g]),
      .flag     (flags[g])
    );
  end

  // Merge stage: a set is taken only when no lane went over the limit.
  always_comb begin
    any_over    = 1'b0;
    any_changed = 1'b0;
    all_zero    = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      any_over    = any_over | flags[i].over;
      any_changed = any_changed | flags[i].changed;
      all_zero    = all_zero & flags[i].zero;
    end
  end

  always_comb begin
    set_en     = 1'b0;
    restore_en = 1'b0;
    muted_nxt  = muted_r;
    pin_nxt    = pin_r;
    case (func)
      FN_SET, FN_SET_ALL: begin
        set_en = 1'b1;
      end
      FN_STEP_UP, FN_STEP_DOWN: begin
        set_en    = any_changed;
        muted_nxt = 1'b0;
        if (muted_r && hard_mode) begin
          pin_nxt = 1'b1;
        end
      end
      FN_MUTE: begin
        set_en = !hard_mode;
        if (hard_mode) begin
          pin_nxt = 1'b0;
        end
      end
      FN_TOGGLE_MUTE: begin
        set_en     = !muted_r && !hard_mode;
        restore_en = muted_r && !hard_mode;
        if (hard_mode) begin
          pin_nxt = muted_r;
        end
      end
      FN_RESTORE: begin
        restore_en = 1'b1;
      end
      default: begin
      end
    endcase

    set_apply = set_en && !any_over;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    if (set_apply) begin
      prev_nxt  = cur_r;
      cur_nxt   = cand;
      muted_nxt = !hard_mode && all_zero;
    end else if (restore_en) begin
      prev_nxt = cur_r;
      cur_nxt  = prev_r;
    end
    // Mute and toggle settle the flag last, over what a set would leave.
    if (func == FN_MUTE) begin
      muted_nxt = 1'b1;
    end else if (func == FN_TOGGLE_MUTE) begin
      muted_nxt = !muted_r;
    end

    res.frame_valid = set_apply || restore_en;
    res.frame_word  = set_apply ? cand : (restore_en ? prev_r : '0);
    res.mute_pin    = hard_mode ? pin_nxt : 1'b1;
    res.muted_now   = muted_nxt;
    res.shown       = muted_nxt ? '0 : cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      prev_r  <= '0;
      muted_r <= 1'b0;
      pin_r   <= 1'b1;
    end else if (fire) begin
      cur_r   <= cur_nxt;
      prev_r  <= prev_nxt;
      muted_r <= muted_nxt;
      pin_r   <= pin_nxt;
    end
  end

endmodule

FILE: src/four_channel_volume_controller.sv
// Top level: configuration registers, input handshake and the registered result beat.
// The result beat of a command is registered and shown in the cycle after the command is taken.
// Throughput: one command per cycle while in_stall is low; the four channel lanes decide in the accept cycle.
// A waiting result holds only while out_stall is high; the input is stalled just then.
// Reset (rst_n low, synchronous) clears all gains and the muted flag, sets the mute
// pin level high and loads the registers with soft mode, limit 255, zero cross high.
`timescale 1ns / 1ps

module four_channel_volume_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vcc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [vcc_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_func,
  input  logic [7:0]                    in_gain_ch1,
  input  logic [7:0]                    in_gain_ch2,
  input  logic [7:0]                    in_gain_ch3,
  input  logic [7:0]                    in_gain_ch4,
  input  logic [7:0]                    in_step_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_frame_valid,
  output logic [31:0]                   out_frame_word,
  output logic                          out_mute_pin,
  output logic                          out_muted_now,
  output logic [7:0]                    out_shown_ch1,
  output logic [7:0]                    out_shown_ch2,
  output logic [7:0]                    out_shown_ch3,
  output logic [7:0]                    out_shown_ch4,
  output logic                          out_zero_cross_pin
);
  import vcc_pkg::*;

  logic        hard_r;
  gain_t       max_r;
  logic        zc_r;
  logic        fire;
  logic        out_valid_r, out_valid_nxt;
  vcc_result_t res;
  vcc_result_t res_r;
  logic        zc_out_r;
  gain_vec_t   gains;

  assign fire     = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign gains    = {in_gain_ch4, in_gain_ch3, in_gain_ch2, in_gain_ch1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_r <= 1'b0;
      max_r  <= '1;
      zc_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HARD_MUTE:  hard_r <= cfg_wdata[0];
        CFG_MAX_GAIN:   max_r  <= cfg_wdata[GAIN_BITS-1:0];
        CFG_ZERO_CROSS: zc_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  vcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .func      (func_t'(in_func)),
    .gains     (gains),
    .step      (in_step_size),
    .hard_mode (hard_r),
    .gain_cap  (max_r),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r    <= res;
      zc_out_r <= zc_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_valid    = res_r.frame_valid;
  assign out_frame_word     = res_r.frame_word;
  assign out_mute_pin       = res_r.mute_pin;
  assign out_muted_now      = res_r.muted_now;
  assign out_shown_ch1      = res_r.shown[0];
  assign out_shown_ch2      = res_r.shown[1];
  assign out_shown_ch3      = res_r.shown[2];
  assign out_shown_ch4      = res_r.shown[3];
  assign out_zero_cross_pin = zc_out_r;

endmodule

FILE: src/vcc_checker.sv
// Port checker for the volume controller, bound to the top level.
`timescale 1ns / 1ps

module vcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_frame_valid,
  input logic [31:0] out_frame_word,
  input logic        out_muted_now,
  input logic [7:0]  out_shown_ch1,
  input logic [7:0]  out_shown_ch2,
  input logic [7:0]  out_shown_ch3,
  input logic [7:0]  out_shown_ch4
);

  // A beat without a frame carries an all-zero frame word.
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_valid) |-> (out_frame_word == 32'd0))
    else $error("frame word not zero on a beat without a frame");

  // Gains read zero while muted.
  a_muted_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_muted_now) |->
      (out_shown_ch1 == 8'd0 && out_shown_ch2 == 8'd0 &&
       out_shown_ch3 == 8'd0 && out_shown_ch4 == 8'd0))
    else $error("nonzero gain shown while muted");

  // The input is held back only by a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no waiting result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind four_channel_volume_controller vcc_checker u_vcc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_frame_valid (out_frame_valid),
  .out_frame_word  (out_frame_word),
  .out_muted_now   (out_muted_now),
  .out_shown_ch1   (out_shown_ch1),
  .out_shown_ch2   (out_shown_ch2),
  .out_shown_ch3   (out_shown_ch3),
  .out_shown_ch4   (out_shown_ch4)
);

FILE: test/tb.sv
// Self-checking testbench for the four channel volume controller: random command beats against a predictor.
`timescale 1ns / 1ps

module tb;
  import vcc_pkg::*;

  localparam int PHASE_ITEMS   = 250;
  localparam int RANDOM_PHASES = 8;
  localparam int HOLD_AT       = 650;
  localparam int HOLD_CYCLES   = 400;
  localparam int STUCK_LIMIT   = 4000;

  typedef struct packed {
    func_t     func;
    gain_vec_t gain;
    gain_t     step;
  } vol_cmd_t;

  typedef struct packed {
    logic        frame_valid;
    logic [31:0] frame_word;
    logic        mute_pin;
    logic        muted_now;
    gain_vec_t   shown;
    logic        zero_cross;
  } vol_beat_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_LIGHT,
    ST_HEAVY,
    ST_PERIODIC
  } stall_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [2:0]              in_func = '0;
  logic [7:0]              in_gain_ch1 = '0;
  logic [7:0]              in_gain_ch2 = '0;
  logic [7:0]              in_gain_ch3 = '0;
  logic [7:0]              in_gain_ch4 = '0;
  logic [7:0]              in_step_size = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_frame_valid;
  logic [31:0]             out_frame_word;
  logic                    out_mute_pin;
  logic                    out_muted_now;
  logic [7:0]              out_shown_ch1;
  logic [7:0]              out_shown_ch2;
  logic [7:0]              out_shown_ch3;
  logic [7:0]              out_shown_ch4;
  logic                    out_zero_cross_pin;

  four_channel_volume_controller u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_gain_ch1       (in_gain_ch1),
    .in_gain_ch2       (in_gain_ch2),
    .in_gain_ch3       (in_gain_ch3),
    .in_gain_ch4       (in_gain_ch4),
    .in_step_size      (in_step_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_valid   (out_frame_valid),
    .out_frame_word    (out_frame_word),
    .out_mute_pin      (out_mute_pin),
    .out_muted_now     (out_muted_now),
    .out_shown_ch1     (out_shown_ch1),
    .out_shown_ch2     (out_shown_ch2),
    .out_shown_ch3     (out_shown_ch3),
    .out_shown_ch4     (out_shown_ch4),
    .out_zero_cross_pin(out_zero_cross_pin)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vol_cmd_t  pending_cmds[$];
  vol_beat_t expected_beats[$];
  int        mismatches = 0;
  int        beats_seen = 0;
  int        stuck_cycles = 0;

  // Shadow of the gain state and the register settings.
  gain_vec_t cur_gain = '0;
  gain_vec_t prev_gain = '0;
  logic      muted_q = 1'b0;
  logic      pin_q = 1'b1;
  logic      hard_mode = 1'b0;
  gain_t     gain_limit = 8'hFF;
  logic      zc_level = 1'b1;
  logic      frame_sent;
  gain_vec_t frame_gains;

  // A set is taken whole or not at all.
  function automatic void load_gains(gain_vec_t g);
    int ch;
    for (ch = 0; ch < CHANNELS; ch++)
      if (g[ch] > gain_limit) return;
    frame_sent  = 1'b1;
    frame_gains = g;
    prev_gain   = cur_gain;
    cur_gain    = g;
    muted_q     = !hard_mode && (g == '0);
  endfunction

  function automatic void swap_gains();
    gain_vec_t held;
    frame_sent  = 1'b1;
    frame_gains = prev_gain;
    held        = cur_gain;
    cur_gain    = prev_gain;
    prev_gain   = held;
  endfunction

  function automatic void mute_all();
    if (hard_mode) pin_q = 1'b0;
    else load_gains('0);
    muted_q = 1'b1;
  endfunction

  function automatic void step_gains(bit up, gain_t amount);
    gain_vec_t n;
    int        ch;
    int        sum;
    bit        changed;
    changed = 1'b0;
    if (muted_q) begin
      if (hard_mode) pin_q = 1'b1;
      muted_q = 1'b0;
    end
    for (ch = 0; ch < CHANNELS; ch++) begin
      if (up) begin
        sum   = int'(cur_gain[ch]) + int'(amount);
        n[ch] = (sum > int'(gain_limit)) ? gain_limit : gain_t'(sum);
      end else begin
        n[ch] = (amount > cur_gain[ch]) ? gain_t'(0) : gain_t'(cur_gain[ch] - amount);
      end
      if (n[ch] != cur_gain[ch]) changed = 1'b1;
    end
    if (changed) load_gains(n);
  endfunction

  function automatic vol_beat_t predict_beat(vol_cmd_t c);
    vol_beat_t b;
    frame_sent  = 1'b0;
    frame_gains = '0;
    case (c.func)
      FN_SET:       load_gains(c.gain);
      FN_SET_ALL:   load_gains({CHANNELS{c.gain[0]}});
      FN_STEP_UP:   step_gains(1'b1, c.step);
      FN_STEP_DOWN: step_gains(1'b0, c.step);
      FN_MUTE:      mute_all();
      FN_TOGGLE_MUTE: begin
        if (muted_q) begin
          if (hard_mode) pin_q = 1'b1;
          else swap_gains();
          muted_q = 1'b0;
        end else begin
          mute_all();
        end
      end
      FN_RESTORE:   swap_gains();
      default: ;
    endcase
    b.frame_valid = frame_sent;
    b.frame_word  = frame_sent ? frame_gains : '0;
    // In soft mode the pin level is kept but always reads high.
    b.mute_pin    = hard_mode ? pin_q : 1'b1;
    b.muted_now   = muted_q;
    b.shown       = muted_q ? '0 : cur_gain;
    b.zero_cross  = zc_level;
    return b;
  endfunction

  task automatic push_cmd(func_t f, gain_t g1, gain_t g2, gain_t g3, gain_t g4, gain_t s);
    vol_cmd_t c;
    c.func = f;
    c.gain = {g4, g3, g2, g1};
    c.step = s;
    pending_cmds.push_back(c);
  endtask

  function automatic gain_t pick_gain();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 11) return gain_t'($urandom_range(0, gain_limit));
    if (r == 11) return '0;
    if (r == 12) return gain_limit;
    if (r == 13) return gain_limit + 1'b1;
    return gain_t'($urandom_range(0, 255));
  endfunction

  function automatic gain_t pick_step();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return gain_t'($urandom_range(0, 8));
    if (r == 5) return '0;
    if (r == 6) return 8'hFF;
    if (r == 7) return gain_limit;
    return gain_t'($urandom_range(0, 255));
  endfunction

  function automatic vol_cmd_t random_cmd();
    vol_cmd_t    c;
    int unsigned r;
    int          ch;
    r = $urandom_range(0, 99);
    if (r < 20)      c.func = FN_SET;
    else if (r < 30) c.func = FN_SET_ALL;
    else if (r < 50) c.func = FN_STEP_UP;
    else if (r < 70) c.func = FN_STEP_DOWN;
    else if (r < 78) c.func = FN_MUTE;
    else if (r < 90) c.func = FN_TOGGLE_MUTE;
    else if (r < 97) c.func = FN_RESTORE;
    else             c.func = FN_NOP;
    for (ch = 0; ch < CHANNELS; ch++) c.gain[ch] = pick_gain();
    c.step = pick_step();
    return c;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_HARD_MUTE:  hard_mode  = value[0];
      CFG_MAX_GAIN:   gain_limit = value;
      CFG_ZERO_CROSS: zc_level   = value[0];
      default: ;
    endcase
  endtask

  // Registers may only change once the block has gone quiet.
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at result %0d, %s: expected %h, got %h",
                 beats_seen, fname, want_v, got_v);
    end
  endtask

  // Command driver: bursts of beats separated by random gaps.
  vol_cmd_t offered;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_beats.push_back(predict_beat(offered));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          offered = pending_cmds.pop_front();
          in_func      <= offered.func;
          in_gain_ch1  <= offered.gain[0];
          in_gain_ch2  <= offered.gain[1];
          in_gain_ch3  <= offered.gain[2];
          in_gain_ch4  <= offered.gain[3];
          in_step_size <= offered.step;
          in_valid     <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern.
  stall_mode_t stall_mode = ST_NONE;
  int          seg_left = 0;
  int          stall_period = 2;
  int          stall_tick = 0;
  int          hold_left = 0;

  always @(posedge clk) begin
    vol_beat_t got;
    vol_beat_t want;
    logic      stall_nxt;
    int        ch;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.frame_valid = out_frame_valid;
        got.frame_word  = out_frame_word;
        got.mute_pin    = out_mute_pin;
        got.muted_now   = out_muted_now;
        got.shown       = {out_shown_ch4, out_shown_ch3, out_shown_ch2, out_shown_ch1};
        got.zero_cross  = out_zero_cross_pin;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat %0d arrived with nothing expected", beats_seen);
        end else begin
          want = expected_beats.pop_front();
          check_field("frame_valid", want.frame_valid, got.frame_valid);
          check_field("frame_word", want.frame_word, got.frame_word);
          check_field("mute_pin", want.mute_pin, got.mute_pin);
          check_field("muted_now", want.muted_now, got.muted_now);
          for (ch = 0; ch < CHANNELS; ch++)
            check_field($sformatf("shown_ch%0d", ch + 1), want.shown[ch], got.shown[ch]);
          check_field("zero_cross_pin", want.zero_cross, got.zero_cross);
        end
        beats_seen++;
        // One long hold-off so the block backs up and stalls its input.
        if (beats_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (pending_cmds.size() == 0 && !in_valid && expected_beats.size() == 0))
        stuck_cycles = 0;
      else
        stuck_cycles++;

      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else begin
        if (seg_left == 0) begin
          stall_mode   = stall_mode_t'($urandom_range(0, 3));
          seg_left     = $urandom_range(16, 200);
          stall_period = $urandom_range(2, 9);
        end
        seg_left--;
        stall_tick++;
        case (stall_mode)
          ST_NONE:  stall_nxt = 1'b0;
          ST_LIGHT: stall_nxt = ($urandom_range(0, 3) == 0);
          ST_HEAVY: stall_nxt = ($urandom_range(0, 3) != 0);
          default:  stall_nxt = (stall_tick % stall_period) < (stall_period / 2);
        endcase
      end
      out_stall <= stall_nxt;
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("tb failed");
    $finish;
  end

  initial begin
    int    p;
    int    k;
    logic  hard_v;
    gain_t max_v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Soft mute with the reset limit.
    push_cmd(FN_SET,         8'hFF, 8'h00, 8'h80, 8'h01, 8'h00);
    push_cmd(FN_SET_ALL,     8'h55, 8'hAA, 8'h33, 8'hCC, 8'h00);
    push_cmd(FN_STEP_UP,     8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    push_cmd(FN_STEP_DOWN,   8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
    push_cmd(FN_STEP_DOWN,   8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    push_cmd(FN_STEP_UP,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_SET,         8'h10, 8'h20, 8'h30, 8'h40, 8'h00);
    push_cmd(FN_MUTE,        8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_TOGGLE_MUTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_TOGGLE_MUTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_RESTORE,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_NOP,         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(FN_SET_ALL,     8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    drain();

    // A lowered limit rejects sets above it and caps steps.
    write_reg(CFG_MAX_GAIN, 8'h40);
    push_cmd(FN_SET,         8'h41, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_SET_ALL,     8'h40, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_STEP_UP,     8'h00, 8'h00, 8'h00, 8'h00, 8'h80);
    push_cmd(FN_STEP_DOWN,   8'h00, 8'h00, 8'h00, 8'h00, 8'h10);
    drain();

    // Hard mute through the pin.
    write_reg(CFG_HARD_MUTE, 8'h01);
    write_reg(CFG_MAX_GAIN, 8'hFF);
    write_reg(CFG_ZERO_CROSS, 8'h00);
    push_cmd(FN_SET,         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    push_cmd(FN_MUTE,        8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_STEP_DOWN,   8'h00, 8'h00, 8'h00, 8'h00, 8'h10);
    push_cmd(FN_TOGGLE_MUTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_TOGGLE_MUTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_SET_ALL,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(FN_MUTE,        8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();

    // Random phases; gains carry over so a new limit can sit below them.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      hard_v = (p < 4) ? p[0] : logic'($urandom_range(0, 1));
      case (p)
        0, 4:    max_v = 8'hFF;
        1:       max_v = 8'h00;
        3:       max_v = 8'h01;
        5:       max_v = gain_t'($urandom_range(8, 64));
        6:       max_v = 8'hFE;
        default: max_v = gain_t'($urandom_range(0, 255));
      endcase
      write_reg(CFG_HARD_MUTE, {7'b0, hard_v});
      write_reg(CFG_MAX_GAIN, max_v);
      write_reg(CFG_ZERO_CROSS, {7'b0, logic'($urandom_range(0, 1))});
      for (k = 0; k < PHASE_ITEMS; k++)
        pending_cmds.push_back(random_cmd());
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
